FILE: hdl/ugf_pkg.sv
// ----------------------------------------------------------------------------
// ugf_pkg
// Shared widths, command codes and controller/datapath structs for the
// uplink symbol gap filler.
// ----------------------------------------------------------------------------
`default_nettype none

package ugf_pkg;

	localparam int ANT_W   = 4;
	localparam int SLOT_W  = 5;
	localparam int SYM_W   = 4;
	localparam int FRAME_W = 8;
	localparam int CNT_W   = 9;

	localparam logic CMD_PACKET  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;    // input transfer: latch target, clear counts, apply release
		logic step;    // zero-fill the expected position and advance
		logic finish;  // write the packet's own position, load result, advance
	} ugf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pkt_ok;     // input is a packet for this antenna, in range
		logic at_target;  // expected position equals the packet's position
	} ugf_sts_t;

endpackage

`default_nettype wire

FILE: hdl/ugf_in_if.sv
// ----------------------------------------------------------------------------
// ugf_in_if
// Input channel: symbol packet or slot release, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ugf_in_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [ugf_pkg::ANT_W-1:0]  antenna;
	logic [ugf_pkg::SLOT_W-1:0] slot;
	logic [ugf_pkg::SYM_W-1:0]  symbol;

	modport source (output valid, cmd, antenna, slot, symbol, input ready);
	modport sink   (input valid, cmd, antenna, slot, symbol, output ready);
endinterface

`default_nettype wire

FILE: hdl/ugf_out_if.sv
// ----------------------------------------------------------------------------
// ugf_out_if
// Result channel: write position, gap length and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ugf_out_if;
	logic                        valid;
	logic                        ready;
	logic [ugf_pkg::FRAME_W-1:0] frame;
	logic [ugf_pkg::SLOT_W-1:0]  write_slot;
	logic [ugf_pkg::SYM_W-1:0]   write_symbol;
	logic [ugf_pkg::CNT_W-1:0]   filled_count;
	logic [ugf_pkg::CNT_W-1:0]   fill_overflows;
	logic                        overflow;
	logic                        out_of_order;

	modport source (output valid, frame, write_slot, write_symbol, filled_count,
		fill_overflows, overflow, out_of_order, input ready);
	modport sink   (input valid, frame, write_slot, write_symbol, filled_count,
		fill_overflows, overflow, out_of_order, output ready);
endinterface

`default_nettype wire

FILE: hdl/ugf_ctrl.sv
// ----------------------------------------------------------------------------
// ugf_ctrl
// Sequencer: takes one item, walks the gap one position a cycle, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ugf_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  ugf_pkg::ugf_sts_t sts,
	output ugf_pkg::ugf_cmd_t cmd
);
	import ugf_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t state_q;
	logic   out_free;
	logic   in_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd        = '0;
		cmd.load   = in_xfer;
		cmd.step   = (state_q == ST_WALK) && !sts.at_target;
		cmd.finish = (state_q == ST_WALK) && sts.at_target && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && sts.pkt_ok)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (cmd.finish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ugf_datapath.sv
// ----------------------------------------------------------------------------
// ugf_datapath
// Expected position, busy bitmap, gap counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ugf_datapath #(
	parameter int SYMBOLS_PER_SLOT = 14,
	parameter int SLOTS_PER_FRAME  = 20
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [ugf_pkg::ANT_W-1:0]   cfg_wdata,
	input  wire                         in_cmd,
	input  wire  [ugf_pkg::ANT_W-1:0]   in_antenna,
	input  wire  [ugf_pkg::SLOT_W-1:0]  in_slot,
	input  wire  [ugf_pkg::SYM_W-1:0]   in_symbol,
	input  ugf_pkg::ugf_cmd_t           cmd,
	output ugf_pkg::ugf_sts_t           sts,
	output logic [ugf_pkg::FRAME_W-1:0] res_frame,
	output logic [ugf_pkg::SLOT_W-1:0]  res_slot,
	output logic [ugf_pkg::SYM_W-1:0]   res_symbol,
	output logic [ugf_pkg::CNT_W-1:0]   res_filled,
	output logic [ugf_pkg::CNT_W-1:0]   res_fovf,
	output logic                        res_overflow,
	output logic                        res_ooo
);
	import ugf_pkg::*;

	localparam int SLOT_IW = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;
	localparam int SYM_IW  = (SYMBOLS_PER_SLOT > 1) ? $clog2(SYMBOLS_PER_SLOT) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_FRAME - 1);
	localparam logic [SYM_W-1:0]  SYM_LAST  = SYM_W'(SYMBOLS_PER_SLOT - 1);
	localparam logic [SLOT_W:0]   SLOT_LIM  = (SLOT_W + 1)'(SLOTS_PER_FRAME);
	localparam logic [SYM_W:0]    SYM_LIM   = (SYM_W + 1)'(SYMBOLS_PER_SLOT);

	logic [ANT_W-1:0]            antenna_q;
	logic [SLOT_W-1:0]           exp_slot_q;
	logic [SYM_W-1:0]            exp_sym_q;
	logic [FRAME_W-1:0]          frame_q;
	logic [SLOT_W-1:0]           tgt_slot_q;
	logic [SYM_W-1:0]            tgt_sym_q;
	logic [CNT_W-1:0]            filled_q;
	logic [CNT_W-1:0]            fovf_q;
	logic [SYMBOLS_PER_SLOT-1:0] busy_q [SLOTS_PER_FRAME];

	logic              slot_ok;
	logic              sym_ok;
	logic              release_hit;
	logic              cur_busy;
	logic              mark;
	logic [SLOT_IW-1:0] cur_row;
	logic [SYM_IW-1:0]  cur_col;

	assign slot_ok     = {1'b0, in_slot} < SLOT_LIM;
	assign sym_ok      = {1'b0, in_symbol} < SYM_LIM;
	assign release_hit = cmd.load && (in_cmd == CMD_RELEASE) && slot_ok;

	assign sts.pkt_ok    = (in_cmd == CMD_PACKET) && (in_antenna == antenna_q)
		&& slot_ok && sym_ok;
	assign sts.at_target = (exp_slot_q == tgt_slot_q) && (exp_sym_q == tgt_sym_q);

	assign cur_row  = exp_slot_q[SLOT_IW-1:0];
	assign cur_col  = exp_sym_q[SYM_IW-1:0];
	assign cur_busy = busy_q[cur_row][cur_col];
	assign mark     = cmd.step || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			antenna_q <= '0;
		end else if (cfg_we) begin
			antenna_q <= cfg_wdata;
		end
	end

	// expected position walks forward one step per marked position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_slot_q <= '0;
			exp_sym_q  <= '0;
			frame_q    <= '0;
		end else if (mark) begin
			if (exp_sym_q == SYM_LAST) begin
				exp_sym_q <= '0;
				if (exp_slot_q == SLOT_LAST) begin
					exp_slot_q <= '0;
					frame_q    <= frame_q + FRAME_W'(1);
				end else begin
					exp_slot_q <= exp_slot_q + SLOT_W'(1);
				end
			end else begin
				exp_sym_q <= exp_sym_q + SYM_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_slot_q <= '0;
			tgt_sym_q  <= '0;
			filled_q   <= '0;
			fovf_q     <= '0;
		end else if (cmd.load) begin
			tgt_slot_q <= in_slot;
			tgt_sym_q  <= in_symbol;
			filled_q   <= '0;
			fovf_q     <= '0;
		end else if (cmd.step) begin
			filled_q <= filled_q + CNT_W'(1);
			if (cur_busy)
				fovf_q <= fovf_q + CNT_W'(1);
		end
	end

	// busy bitmap: release clears a row, fill and write set one bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS_PER_FRAME; i++)
				busy_q[i] <= '0;
		end else if (release_hit) begin
			busy_q[in_slot[SLOT_IW-1:0]] <= '0;
		end else if (mark) begin
			busy_q[cur_row][cur_col] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_frame    <= frame_q;
			res_slot     <= exp_slot_q;
			res_symbol   <= exp_sym_q;
			res_filled   <= filled_q;
			res_fovf     <= fovf_q;
			res_overflow <= cur_busy;
			res_ooo      <= (filled_q != '0);
		end
	end

endmodule

`default_nettype wire

FILE: hdl/uplink_symbol_gap_filler_unit.sv
// ----------------------------------------------------------------------------
// uplink_symbol_gap_filler_unit
// Tracks the expected uplink position, zero-fills gaps in a per-slot busy
// bitmap and reports write position, gap length and overflows per packet.
// ----------------------------------------------------------------------------
// One item is taken at a time. A release or a dropped packet (other antenna,
// position out of range) is done on its input transfer. An accepted packet
// then walks the G missing positions before it: the busy bitmap is marked and
// the expected position advanced one position per cycle, then its own position
// is written and advanced past. The result sits in an output register, so the
// next item is taken while it waits; a packet only stalls in its final cycle if
// the previous result has still not been transferred. Busy bits are cleared at reset.
`default_nettype none

module uplink_symbol_gap_filler_unit #(
	parameter int SYMBOLS_PER_SLOT = 14,
	parameter int SLOTS_PER_FRAME  = 20
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [ugf_pkg::ANT_W-1:0] cfg_wdata,
	ugf_in_if.sink                    in_ch,
	ugf_out_if.source                 out_ch
);
	import ugf_pkg::*;

	ugf_cmd_t cmd;
	ugf_sts_t sts;

	ugf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ugf_datapath #(
		.SYMBOLS_PER_SLOT (SYMBOLS_PER_SLOT),
		.SLOTS_PER_FRAME  (SLOTS_PER_FRAME)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_cmd       (in_ch.cmd),
		.in_antenna   (in_ch.antenna),
		.in_slot      (in_ch.slot),
		.in_symbol    (in_ch.symbol),
		.cmd          (cmd),
		.sts          (sts),
		.res_frame    (out_ch.frame),
		.res_slot     (out_ch.write_slot),
		.res_symbol   (out_ch.write_symbol),
		.res_filled   (out_ch.filled_count),
		.res_fovf     (out_ch.fill_overflows),
		.res_overflow (out_ch.overflow),
		.res_ooo      (out_ch.out_of_order)
	);

	// out of order exactly when something was zero-filled
	a_ooo_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.out_of_order == (out_ch.filled_count != '0)))
		else $error("out_of_order disagrees with filled_count");

	a_fovf_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.fill_overflows <= out_ch.filled_count))
		else $error("more fill overflows than filled positions");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ((32'(out_ch.write_slot) < SLOTS_PER_FRAME)
			&& (32'(out_ch.write_symbol) < SYMBOLS_PER_SLOT)))
		else $error("write position out of range");

	// an accepted packet keeps the input closed until its result is loaded
	a_busy_after_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && sts.pkt_ok) |=> !in_ch.ready)
		else $error("input reopened while a packet is in progress");

endmodule

`default_nettype wire

FILE: bench/uplink_symbol_gap_filler_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uplink_symbol_gap_filler_unit_test
// Self-checking bench for the uplink symbol gap filler. A directed table
// covers reset, dropped packets, releases, the largest gaps and the frame
// wrap, then random packet streams run under six antenna selections and three
// handshake pressure patterns. Every result is checked against a
// cycle-free tracker of the expected position and the busy bitmap.
// ----------------------------------------------------------------------------

module uplink_symbol_gap_filler_unit_test;
	import ugf_pkg::*;

	localparam int SYMS          = 14;
	localparam int SLOTS         = 20;
	localparam int POSITIONS     = SYMS * SLOTS;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 300;
	localparam int STALL_LIMIT   = 5000;
	localparam int SHOW_LIMIT    = 10;

	typedef struct packed {
		logic              cmd;
		logic [ANT_W-1:0]  antenna;
		logic [SLOT_W-1:0] slot;
		logic [SYM_W-1:0]  symbol;
	} uplink_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [SLOT_W-1:0]  write_slot;
		logic [SYM_W-1:0]   write_symbol;
		logic [CNT_W-1:0]   filled_count;
		logic [CNT_W-1:0]   fill_overflows;
		logic               overflow;
		logic               out_of_order;
	} placement_t;

	typedef enum logic [1:0] {ROW_PLAIN, ROW_KNOWN, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		uplink_item_t     item;
		logic [ANT_W-1:0] antenna_sel;
		placement_t       known;
	} directed_row_t;

	localparam directed_row_t DIRECTED [24] = '{
		'{ROW_KNOWN, '{CMD_PACKET, 4'd0, 5'd0, 4'd0}, 4'd0,
			'{8'd0, 5'd0, 4'd0, 9'd0, 9'd0, 1'b0, 1'b0}},
		'{ROW_KNOWN, '{CMD_PACKET, 4'd0, 5'd0, 4'd1}, 4'd0,
			'{8'd0, 5'd0, 4'd1, 9'd0, 9'd0, 1'b0, 1'b0}},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd5, 5'd0, 4'd2}, 4'd0, '0},      // other antenna
		'{ROW_PLAIN, '{CMD_PACKET, 4'd0, 5'd20, 4'd0}, 4'd0, '0},     // slot out of range
		'{ROW_PLAIN, '{CMD_PACKET, 4'd0, 5'd31, 4'd15}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd0, 5'd0, 4'd14}, 4'd0, '0},     // symbol out of range
		'{ROW_KNOWN, '{CMD_PACKET, 4'd0, 5'd0, 4'd5}, 4'd0,
			'{8'd0, 5'd0, 4'd5, 9'd3, 9'd0, 1'b0, 1'b1}},
		'{ROW_KNOWN, '{CMD_PACKET, 4'd0, 5'd19, 4'd13}, 4'd0,
			'{8'd0, 5'd19, 4'd13, 9'd273, 9'd0, 1'b0, 1'b1}},
		'{ROW_KNOWN, '{CMD_PACKET, 4'd0, 5'd0, 4'd0}, 4'd0,
			'{8'd1, 5'd0, 4'd0, 9'd0, 9'd0, 1'b1, 1'b0}},
		'{ROW_PLAIN, '{CMD_RELEASE, 4'd10, 5'd0, 4'd9}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_RELEASE, 4'd0, 5'd31, 4'd0}, 4'd0, '0},    // ignored release
		// one behind: walks the whole frame, slot 0 freed, the rest still busy
		'{ROW_KNOWN, '{CMD_PACKET, 4'd0, 5'd0, 4'd0}, 4'd0,
			'{8'd2, 5'd0, 4'd0, 9'd279, 9'd266, 1'b0, 1'b1}},
		'{ROW_CFG, '0, 4'd15, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd0, 5'd0, 4'd1}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd15, 5'd0, 4'd1}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_RELEASE, 4'd15, 5'd19, 4'd0}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd15, 5'd19, 4'd13}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd15, 5'd19, 4'd12}, 4'd0, '0},
		'{ROW_CFG, '0, 4'd7, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd7, 5'd3, 4'd7}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd7, 5'd3, 4'd8}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd7, 5'd3, 4'd6}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_PACKET, 4'd7, 5'd3, 4'd14}, 4'd0, '0},
		'{ROW_PLAIN, '{CMD_RELEASE, 4'd7, 5'd20, 4'd0}, 4'd0, '0}
	};

	localparam logic [ANT_W-1:0] ANTENNA_PLAN [6] = '{4'd15, 4'd3, 4'd0, 4'd12, 4'd9, 4'd15};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [ANT_W-1:0] cfg_wdata;

	ugf_in_if  in_ch();
	ugf_out_if out_ch();

	uplink_symbol_gap_filler_unit #(
		.SYMBOLS_PER_SLOT(SYMS),
		.SLOTS_PER_FRAME (SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// tracked block state
	logic [ANT_W-1:0]   trk_antenna = '0;
	logic [SLOT_W-1:0]  trk_slot    = '0;
	logic [SYM_W-1:0]   trk_symbol  = '0;
	logic [FRAME_W-1:0] trk_frame   = '0;
	logic [SYMS-1:0]    trk_busy [SLOTS];

	placement_t awaited_placements [$];

	int mismatches     = 0;
	int packets_placed = 0;
	int releases_done  = 0;
	int items_dropped  = 0;
	int widest_gap     = 0;
	int frame_wraps    = 0;
	int quiet_cycles   = 0;
	int send_idle_pct  = 33;
	int take_idle_pct  = 70;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic occupy_position();
		logic was;
		was = trk_busy[trk_slot][trk_symbol];
		trk_busy[trk_slot][trk_symbol] = 1'b1;
		return was;
	endfunction

	function automatic void step_position();
		if (int'(trk_symbol) == SYMS - 1) begin
			trk_symbol = '0;
			if (int'(trk_slot) == SLOTS - 1) begin
				trk_slot  = '0;
				trk_frame = trk_frame + 1'b1;
				if (trk_frame == '0) frame_wraps++;
			end else begin
				trk_slot = trk_slot + 1'b1;
			end
		end else begin
			trk_symbol = trk_symbol + 1'b1;
		end
	endfunction

	// Applies one item to the tracked state; returns 1 when a placement report is due.
	function automatic logic place_symbol(input uplink_item_t it, output placement_t res);
		int filled;
		int clashes;
		filled  = 0;
		clashes = 0;
		res     = '0;
		if (it.cmd == CMD_RELEASE) begin
			if (int'(it.slot) < SLOTS) begin
				trk_busy[it.slot] = '0;
				releases_done++;
			end else begin
				items_dropped++;
			end
			return 1'b0;
		end
		if (it.antenna != trk_antenna || int'(it.slot) >= SLOTS || int'(it.symbol) >= SYMS) begin
			items_dropped++;
			return 1'b0;
		end
		res.out_of_order = (it.slot != trk_slot) || (it.symbol != trk_symbol);
		// zero-fill forward, wrapping through the frame if the packet is behind
		while ((it.slot != trk_slot || it.symbol != trk_symbol) && filled < POSITIONS) begin
			if (occupy_position()) clashes++;
			filled++;
			step_position();
		end
		res.frame          = trk_frame;
		res.write_slot     = trk_slot;
		res.write_symbol   = trk_symbol;
		res.overflow       = occupy_position();
		step_position();
		res.filled_count   = CNT_W'(filled);
		res.fill_overflows = CNT_W'(clashes);
		if (filled > widest_gap) widest_gap = filled;
		packets_placed++;
		return 1'b1;
	endfunction

	// Mostly well-formed streams from the selected antenna, with gaps,
	// backward jumps, consumer releases and some noise.
	function automatic uplink_item_t next_random_item();
		uplink_item_t it;
		int pick;
		int offset;
		int lin;
		pick = $urandom_range(99);
		if (pick < 45)      offset = 0;
		else if (pick < 55) offset = $urandom_range(5, 1);
		else if (pick < 65) offset = POSITIONS - 1;
		else                offset = $urandom_range(POSITIONS - 1);
		lin = (int'(trk_slot) * SYMS + int'(trk_symbol) + offset) % POSITIONS;
		it.cmd     = CMD_PACKET;
		it.antenna = trk_antenna;
		it.slot    = SLOT_W'(lin / SYMS);
		it.symbol  = SYM_W'(lin % SYMS);
		if (pick >= 97) begin
			it.cmd     = 1'($urandom);
			it.antenna = ANT_W'($urandom);
			it.slot    = SLOT_W'($urandom);
			it.symbol  = SYM_W'($urandom);
		end else if (pick >= 91) begin
			if ($urandom_range(1) == 0) it.slot = SLOT_W'($urandom_range(31, SLOTS));
			else                        it.symbol = SYM_W'($urandom_range(15, SYMS));
		end else if (pick >= 84) begin
			it.antenna = trk_antenna + ANT_W'($urandom_range(15, 1));
		end else if (pick >= 72) begin
			it.cmd     = CMD_RELEASE;
			it.antenna = ANT_W'($urandom);
			// usually a slot the consumer has just finished with
			if ($urandom_range(3) != 0)
				it.slot = SLOT_W'((int'(trk_slot) + SLOTS - 1 - int'($urandom_range(2))) % SLOTS);
			else
				it.slot = SLOT_W'($urandom);
		end
		return it;
	endfunction

	function automatic string show_placement(input placement_t p);
		return $sformatf("frame=%0d slot=%0d sym=%0d fill=%0d fovf=%0d ovf=%0b ooo=%0b",
			p.frame, p.write_slot, p.write_symbol, p.filled_count, p.fill_overflows,
			p.overflow, p.out_of_order);
	endfunction

	function automatic string field_diffs(input placement_t want, input placement_t got);
		string d;
		d = "";
		if (got.frame !== want.frame)                   d = {d, " frame"};
		if (got.write_slot !== want.write_slot)         d = {d, " write_slot"};
		if (got.write_symbol !== want.write_symbol)     d = {d, " write_symbol"};
		if (got.filled_count !== want.filled_count)     d = {d, " filled_count"};
		if (got.fill_overflows !== want.fill_overflows) d = {d, " fill_overflows"};
		if (got.overflow !== want.overflow)             d = {d, " overflow"};
		if (got.out_of_order !== want.out_of_order)     d = {d, " out_of_order"};
		return d;
	endfunction

	task automatic note_mismatch(input string what, input string want, input string got);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("%0t: %s\n  expected: %s\n  actual:   %s", $realtime, what, want, got);
	endtask

	// Offers one item and waits for its transfer; valid stays high into the next
	// item unless the sender decides to idle.
	task automatic put_item(input uplink_item_t it, input logic known, input placement_t want);
		placement_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.cmd     <= it.cmd;
		in_ch.antenna <= it.antenna;
		in_ch.slot    <= it.slot;
		in_ch.symbol  <= it.symbol;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		if (place_symbol(it, res)) awaited_placements.push_back(known ? want : res);
	endtask

	task automatic write_antenna_select(input logic [ANT_W-1:0] sel);
		in_ch.valid <= 1'b0;
		while (awaited_placements.size() != 0) @(posedge clk);
		// a dropped item or release may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= sel;
		@(posedge clk);
		cfg_we      <= 1'b0;
		trk_antenna = sel;
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	always @(posedge clk) begin
		placement_t got;
		placement_t want;
		string diffs;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got = {out_ch.frame, out_ch.write_slot, out_ch.write_symbol, out_ch.filled_count,
				out_ch.fill_overflows, out_ch.overflow, out_ch.out_of_order};
			if (awaited_placements.size() == 0) begin
				note_mismatch("result transfer with nothing awaited", "none", show_placement(got));
			end else begin
				want  = awaited_placements.pop_front();
				diffs = field_diffs(want, got);
				if (diffs != "")
					note_mismatch({"wrong field(s):", diffs}, show_placement(want),
						show_placement(got));
			end
		end
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, awaited_placements.size());
			$display("** uplink_symbol_gap_filler_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int target;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		in_ch.valid   <= 1'b0;
		in_ch.cmd     <= CMD_PACKET;
		in_ch.antenna <= '0;
		in_ch.slot    <= '0;
		in_ch.symbol  <= '0;
		foreach (trk_busy[s]) trk_busy[s] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			case (DIRECTED[i].kind)
				ROW_CFG:   write_antenna_select(DIRECTED[i].antenna_sel);
				ROW_KNOWN: put_item(DIRECTED[i].item, 1'b1, DIRECTED[i].known);
				default:   put_item(DIRECTED[i].item, 1'b0, '0);
			endcase
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 33;
					take_idle_pct = 70;
				end
				1: begin
					send_idle_pct = 70;
					take_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 2; k++) begin
				write_antenna_select(ANTENNA_PLAN[2 * ph + k]);
				target = packets_placed + releases_done + items_dropped + RANDOM_ITEMS / 6;
				while (packets_placed + releases_done + items_dropped < target)
					put_item(next_random_item(), 1'b0, '0);
			end
		end
		in_ch.valid <= 1'b0;

		while (awaited_placements.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d placed packets, %0d slot releases and %0d dropped items",
			packets_placed, releases_done, items_dropped);
		$display("under six antenna selections; widest gap %0d, frame counter wrapped %0d time(s).",
			widest_gap, frame_wraps);
		if (mismatches == 0) begin
			$display("** uplink_symbol_gap_filler_unit: PASSED **");
		end else begin
			$display("%0d mismatch(es) in total", mismatches);
			$display("** uplink_symbol_gap_filler_unit: FAILED **");
		end
		$finish;
	end

endmodule
